### rtl/core/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and helpers for the UTF-8 to UTF-16 transcoder
// Lead byte classification, single-byte decode and the batch of code units
// handed from the decoder to the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  // code unit emitted for an invalid or cut-off sequence ('#')
  localparam logic [15:0] HASH_UNIT  = 16'h0023;
  // first codepoint that needs a surrogate pair
  localparam logic [20:0] CP_PLANE1  = 21'h010000;
  localparam logic [15:0] HIGH_SURR  = 16'hD800;
  localparam logic [15:0] LOW_SURR   = 16'hDC00;
  // most code units one input byte can produce
  localparam int unsigned MAX_UNITS  = 3;

  // up to three code units from one transaction, unit 0 goes out first
  typedef struct packed {
    logic [MAX_UNITS-1:0][15:0] units;
    logic [1:0]                 count;
    logic                       last;
  } batch_t;

  // sequence length from the top five bits of a lead byte, 0 when invalid
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7]) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // a byte decoded on its own: ascii passes, anything else is '#'
  function automatic logic [15:0] single_unit(input logic [7:0] b);
    logic [15:0] u;
    if (!b[7]) begin
      u = {8'h00, b};
    end else begin
      u = HASH_UNIT;
    end
    return u;
  endfunction

endpackage

`default_nettype wire

### rtl/core/u8u16_decoder.sv
// ----------------------------------------------------------------------------
// u8u16_decoder: sequence state and code unit generation
// Holds the open multi-byte sequence and turns each registered byte into a
// batch of zero to three UTF-16 code units; state moves on when the batch is
// taken by the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decoder
  import u8u16_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_string,
  input  wire logic       advance,
  output batch_t          batch
);

  // open sequence: held bytes have no reset, only written entries are read
  logic [2:0][7:0] held_bytes;
  logic [2:0]      sequence_length;
  logic [1:0]      bytes_held;

  logic [2:0]      sequence_length_next;
  logic [1:0]      bytes_held_next;
  logic            hold_en;

  logic [7:0]      b_lead;
  logic [7:0]      b1;
  logic [7:0]      b2;
  logic [2:0]      lead_l;
  logic [2:0]      n_bytes;
  logic [20:0]     cp;
  logic [20:0]     cp_off;
  logic            needs_pair;
  logic [15:0]     full_u0;
  logic [15:0]     full_u1;
  logic [1:0]      full_cnt;

  // window over held bytes plus the new byte
  always_comb begin
    b_lead  = (bytes_held == 2'd0) ? in_byte : held_bytes[0];
    b1      = (bytes_held == 2'd1) ? in_byte : held_bytes[1];
    b2      = (bytes_held == 2'd2) ? in_byte : held_bytes[2];
    lead_l  = lead_len(b_lead);
    n_bytes = {1'b0, bytes_held} + 3'd1;
  end

  // codepoint of a complete sequence
  always_comb begin
    unique case (lead_l)
      3'd2:    cp = {10'd0, b_lead[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b_lead[3:0], b1[5:0], b2[5:0]};
      3'd4:    cp = {b_lead[2:0], b1[5:0], b2[5:0], in_byte[5:0]};
      default: cp = {13'd0, b_lead};
    endcase
  end

  // surrogate split for codepoints above the basic plane
  always_comb begin
    needs_pair = |cp[20:16];
    cp_off     = cp - CP_PLANE1;
    if (needs_pair) begin
      full_u0  = HIGH_SURR + {5'd0, cp_off[20:10]};
      full_u1  = LOW_SURR + {6'd0, cp_off[9:0]};
      full_cnt = 2'd2;
    end else begin
      full_u0  = cp[15:0];
      full_u1  = HASH_UNIT;
      full_cnt = 2'd1;
    end
  end

  // batch and next state
  always_comb begin
    batch.units          = {HASH_UNIT, HASH_UNIT, HASH_UNIT};
    batch.count          = 2'd0;
    batch.last           = end_of_string;
    sequence_length_next = sequence_length;
    bytes_held_next      = bytes_held;
    hold_en              = 1'b0;
    if (end_of_string) begin
      sequence_length_next = 3'd0;
      bytes_held_next      = 2'd0;
      if (bytes_held == 2'd0) begin
        batch.units[0] = single_unit(in_byte);
        batch.count    = 2'd1;
      end else if (lead_l >= 3'd2 && lead_l <= n_bytes) begin
        batch.units[0] = full_u0;
        batch.units[1] = full_u1;
        batch.count    = full_cnt;
      end else begin
        // cut-off lead gives '#', the bytes after it are decoded again
        batch.units[0] = HASH_UNIT;
        case (bytes_held)
          2'd1: begin
            batch.units[1] = single_unit(in_byte);
            batch.count    = 2'd2;
          end
          2'd2: begin
            if (lead_len(held_bytes[1]) == 3'd2) begin
              batch.units[1] = {5'd0, held_bytes[1][4:0], in_byte[5:0]};
              batch.count    = 2'd2;
            end else begin
              batch.units[1] = single_unit(held_bytes[1]);
              batch.units[2] = single_unit(in_byte);
              batch.count    = 2'd3;
            end
          end
          default: begin
            batch.units[1] = single_unit(held_bytes[1]);
            batch.units[2] = single_unit(held_bytes[2]);
            batch.count    = 2'd3;
          end
        endcase
      end
    end else if (bytes_held == 2'd0) begin
      if (lead_l <= 3'd1) begin
        batch.units[0] = single_unit(in_byte);
        batch.count    = 2'd1;
      end else begin
        hold_en              = 1'b1;
        sequence_length_next = lead_l;
        bytes_held_next      = 2'd1;
      end
    end else if (n_bytes >= sequence_length || bytes_held == 2'd3) begin
      batch.units[0]       = full_u0;
      batch.units[1]       = full_u1;
      batch.count          = full_cnt;
      sequence_length_next = 3'd0;
      bytes_held_next      = 2'd0;
    end else begin
      hold_en         = 1'b1;
      bytes_held_next = bytes_held + 2'd1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_length <= 3'd0;
      bytes_held      <= 2'd0;
    end else if (advance) begin
      sequence_length <= sequence_length_next;
      bytes_held      <= bytes_held_next;
    end
  end

  // held bytes, written at the next free entry
  always_ff @(posedge clk) begin
    if (advance && hold_en) begin
      case (bytes_held)
        2'd0:    held_bytes[0] <= in_byte;
        2'd1:    held_bytes[1] <= in_byte;
        default: held_bytes[2] <= in_byte;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/u8u16_unit_queue.sv
// ----------------------------------------------------------------------------
// u8u16_unit_queue: result register and code unit serializer
// Holds one batch of up to three code units and sends them one per
// transaction; a new batch loads as the last unit of the old one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_unit_queue
  import u8u16_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire batch_t      batch,
  output logic             load_ok,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // code_unit[15:0]
  output logic             m_axis_tlast    // final_unit
);

  logic [MAX_UNITS-1:0][15:0] units;
  logic [1:0]                 count;
  logic                       last;

  // free when empty or when the final unit goes out this cycle
  assign load_ok = (count == 2'd0) || (count == 2'd1 && m_axis_tready);

  // count and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      last  <= 1'b0;
    end else if (load) begin
      count <= batch.count;
      last  <= batch.last;
    end else if (m_axis_tvalid && m_axis_tready) begin
      count <= count - 2'd1;
    end
  end

  // unit payload, shifted toward unit 0 as units leave
  always_ff @(posedge clk) begin
    if (load) begin
      units <= batch.units;
    end else if (m_axis_tvalid && m_axis_tready) begin
      units[0] <= units[1];
      units[1] <= units[2];
    end
  end

  // master side
  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = units[0];
  assign m_axis_tlast  = last && (count == 2'd1);

endmodule

`default_nettype wire

### rtl/core/utf8_to_utf16_transcoder.sv
// A byte taken in is decoded into the result register when it advances; its
// first code unit is offered from then on. One byte per cycle while each byte
// yields at most one unit and the output is ready; the result register sends
// one unit per cycle while not stalled, so a byte giving several units holds
// the input until its last unit leaves. Reset (rst, synchronous) empties the
// input and result registers and closes any open sequence.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder: streaming UTF-8 to UTF-16 conversion
// Input register, sequence decoder and serializing result register; the
// last byte of a string flags the last code unit it produces.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // in_byte[7:0]
  input  wire logic        s_axis_tlast,   // end_of_string
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // code_unit[15:0]
  output logic             m_axis_tlast    // final_unit
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       advance;
  logic       load_ok;
  batch_t     batch;

  // byte moves on once its units fit in the result register
  assign advance       = in_valid && load_ok;
  assign s_axis_tready = !in_valid || advance;

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eos  <= s_axis_tlast;
    end
  end

  u8u16_decoder u_decoder (
    .clk           (clk),
    .rst           (rst),
    .in_byte       (in_byte),
    .end_of_string (in_eos),
    .advance       (advance),
    .batch         (batch)
  );

  u8u16_unit_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .load          (advance),
    .batch         (batch),
    .load_ok       (load_ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

### rtl/core/u8u16_checker.sv
// ----------------------------------------------------------------------------
// u8u16_checker: port-level checks for the transcoder
// Watches both stream sides of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // reset leaves no code unit pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("code unit offered right after reset");

  // input is only held back while units wait on the output
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // a stalled code unit stays in place
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled code unit changed");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (.*);

`default_nettype wire
